// ===== rtl/pad_key_event_generator_defines.svh =====
// Assertion macros for the RTL
`ifndef PAD_KEY_EVENT_GENERATOR_DEFINES_SVH
`define PAD_KEY_EVENT_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PKEG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkeg assertion failed");

// Next-cycle implication, checked outside reset
`define PKEG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkeg assertion failed");

`endif

// ===== rtl/pkeg_pkg.sv =====
package pkeg_pkg;

    localparam int NUM_BUTTONS = 12;
    localparam int NUM_DIRS    = 4;
    localparam int NUM_EVENTS  = NUM_BUTTONS + NUM_DIRS;
    localparam int EVT_IDX_W   = $clog2(NUM_EVENTS);

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD_LOW  = 1'b0,
        REG_THRESHOLD_HIGH = 1'b1
    } cfg_reg_t;

    localparam logic [7:0] THRESHOLD_LOW_RESET  = 8'd80;
    localparam logic [7:0] THRESHOLD_HIGH_RESET = 8'd170;

    // Key code per button bit: up down left right cross circle square triangle L1 R1 start select
    localparam logic [7:0] KEY_CODE [NUM_BUTTONS] = '{
        8'h26, 8'h28, 8'h25, 8'h27, 8'h0D, 8'h1B,
        8'h58, 8'h59, 8'h21, 8'h22, 8'h70, 8'h71
    };

    // Pending events of one sample: bits 0..11 buttons, 12..15 stick up/down/left/right
    typedef struct packed {
        logic [NUM_EVENTS-1:0] mask;
        logic [NUM_EVENTS-1:0] down;
    } evt_set_t;

    // Stick events reuse the code of their direction button (low two index bits)
    function automatic logic [7:0] event_code(logic [EVT_IDX_W-1:0] idx);
        logic [7:0] code;
        if (idx >= EVT_IDX_W'(NUM_BUTTONS))
            code = KEY_CODE[idx[1:0]];
        else
            code = KEY_CODE[idx];
        return code;
    endfunction

endpackage

// ===== rtl/pkeg_if.sv =====
interface pkeg_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] button_bits;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;

    modport source (output valid, output button_bits, output stick_x, output stick_y,
                    input ready);
    modport sink   (input valid, input button_bits, input stick_x, input stick_y,
                    output ready);
endinterface

interface pkeg_event_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       key_down;
    logic       last_event;

    modport source (output valid, output key_code, output key_down, output last_event,
                    input ready);
    modport sink   (input valid, input key_code, input key_down, input last_event,
                    output ready);
endinterface

// ===== rtl/pkeg_front.sv =====
module pkeg_front
    import pkeg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [11:0]            button_bits,
    input  logic [7:0]             stick_x,
    input  logic [7:0]             stick_y,
    input  logic                   q_full,
    output logic                   q_push,
    output evt_set_t               q_data
);

    logic [7:0]             thr_low_reg;
    logic [7:0]             thr_high_reg;
    logic [NUM_BUTTONS-1:0] prev_buttons_reg;
    logic [NUM_DIRS-1:0]    stick_held_reg;
    logic [NUM_DIRS-1:0]    want;
    logic                   accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        want[0] = stick_y < thr_low_reg;
        want[1] = stick_y > thr_high_reg;
        want[2] = stick_x < thr_low_reg;
        want[3] = stick_x > thr_high_reg;
        // a held direction button masks its stick direction
        want    = want & ~button_bits[NUM_DIRS-1:0];
    end

    assign q_data.mask = {want ^ stick_held_reg, button_bits ^ prev_buttons_reg};
    assign q_data.down = {want, button_bits};
    // drop samples that cause no event
    assign q_push      = accept && (q_data.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_low_reg      <= THRESHOLD_LOW_RESET;
            thr_high_reg     <= THRESHOLD_HIGH_RESET;
            prev_buttons_reg <= '0;
            stick_held_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_THRESHOLD_LOW:  thr_low_reg  <= cfg_data[7:0];
                    REG_THRESHOLD_HIGH: thr_high_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                prev_buttons_reg <= button_bits;
                stick_held_reg   <= want;
            end
        end
    end

endmodule

// ===== rtl/pkeg_queue.sv =====
module pkeg_queue
    import pkeg_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH  // power of two, at least 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  evt_set_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output evt_set_t head
);

    localparam int AW = $clog2(Depth);

    evt_set_t      entry_reg [Depth];
    logic [AW:0]   wr_ptr_reg;
    logic [AW:0]   rd_ptr_reg;

    assign head_valid = wr_ptr_reg != rd_ptr_reg;
    assign full       = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                        (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign head       = entry_reg[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg[AW-1:0]] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

// ===== rtl/pkeg_back.sv =====
module pkeg_back
    import pkeg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  evt_set_t   q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] key_code,
    output logic       key_down,
    output logic       last_event
);

    logic [NUM_EVENTS-1:0] rem_reg;
    logic [NUM_EVENTS-1:0] rem_next;
    logic [NUM_EVENTS-1:0] rem_down_reg;
    logic [NUM_EVENTS-1:0] rem_down_next;
    logic                  out_valid_reg;
    logic [7:0]            key_code_reg;
    logic                  key_down_reg;
    logic                  last_reg;

    logic                  busy;
    logic                  have_evt;
    logic                  advance;
    logic [NUM_EVENTS-1:0] src_mask;
    logic [NUM_EVENTS-1:0] src_down;
    logic [NUM_EVENTS-1:0] low_bit;
    logic [EVT_IDX_W-1:0]  idx;

    assign busy     = rem_reg != '0;
    assign have_evt = busy || q_valid;
    assign advance  = !out_valid_reg || out_ready;

    // continue the current sample, else start on the queue head
    assign src_mask = busy ? rem_reg : q_head.mask;
    assign src_down = busy ? rem_down_reg : q_head.down;
    assign low_bit  = src_mask & (~src_mask + 1'b1);

    always_comb
    begin
        idx = '0;
        for (int i = NUM_EVENTS - 1; i >= 0; i--)
        begin
            if (src_mask[i])
                idx = EVT_IDX_W'(i);
        end
    end

    assign q_pop         = advance && !busy && q_valid;
    assign rem_next      = src_mask & ~low_bit;
    assign rem_down_next = src_down;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= have_evt;
            if (have_evt)
                rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && have_evt)
        begin
            rem_down_reg <= rem_down_next;
            key_code_reg <= event_code(idx);
            key_down_reg <= src_down[idx];
            last_reg     <= rem_next == '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_code   = key_code_reg;
    assign key_down   = key_down_reg;
    assign last_event = last_reg;

endmodule

// ===== rtl/pad_key_event_generator.sv =====
// Channel    | Dir | Beat payload                          | Handshake
// sample     | in  | button_bits[11:0] stick_x stick_y     | valid/ready
// key_event  | out | key_code[7:0] key_down last_event     | valid/ready
// cfg        | in  | cfg_index cfg_data[7:0]               | cfg_we only
//
// The front feeds the event queue combinationally; events leave at one beat per cycle while the
// receiver is ready, and a sample carries up to 16 events, split off by the serializer.
// The front takes a new sample each cycle while the event queue has room.
// Samples with no events are consumed without entering the queue.
// rst_n clears thresholds to 80/170, the button and stick history and the queue.
`include "pad_key_event_generator_defines.svh"

module pad_key_event_generator
    import pkeg_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pkeg_sample_if.sink            sample,
    pkeg_event_if.source           key_event
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    evt_set_t q_data;
    evt_set_t q_head;

    pkeg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (sample.valid),
        .in_ready    (sample.ready),
        .button_bits (sample.button_bits),
        .stick_x     (sample.stick_x),
        .stick_y     (sample.stick_y),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    pkeg_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    pkeg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (key_event.valid),
        .out_ready  (key_event.ready),
        .key_code   (key_event.key_code),
        .key_down   (key_event.key_down),
        .last_event (key_event.last_event)
    );

    `PKEG_ASSERT_NOW(a_pop_has_entry, clk, rst_n, q_pop, q_valid)
    `PKEG_ASSERT_NOW(a_queued_nonempty, clk, rst_n, q_valid, q_head.mask != '0)
    `PKEG_ASSERT_NEXT(a_idle_after_last, clk, rst_n,
        key_event.valid && key_event.ready && key_event.last_event && !q_valid,
        !key_event.valid)

endmodule

// ===== test/tb_pad_key_event_generator.sv =====
`timescale 1ns / 100ps

module tb_pad_key_event_generator;
    import pkeg_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int IDLE_PERCENT   = 18;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [11:0] buttons;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
    } pad_sample_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       key_down;
        logic       last_event;
    } key_event_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pkeg_sample_if sample_ch ();
    pkeg_event_if  event_ch ();

    pad_key_event_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .key_event (event_ch)
    );

    // pad state mirrored by the predictor
    logic [7:0]  thr_low;
    logic [7:0]  thr_high;
    logic [11:0] btn_hist;
    logic [3:0]  stick_held;

    pad_sample_t sample_q[$];
    key_event_t  expected_keys[$];
    pad_sample_t next_sample;
    key_event_t  exp_key;

    logic [11:0] gen_buttons;
    bit          no_idle;
    int          stall_req;
    int          stall_ack;
    int          hold_cnt;
    int          mismatches;

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    function automatic void predict_keys(input logic [11:0] buttons,
                                         input logic [7:0] sx,
                                         input logic [7:0] sy);
        logic [11:0] pressed;
        logic [11:0] released;
        logic [3:0]  want;
        logic [3:0]  dir_change;
        int          total;
        int          emitted;
        key_event_t  ev;

        pressed  = buttons & ~btn_hist;
        released = ~buttons & btn_hist;
        want[0] = sy < thr_low;
        want[1] = sy > thr_high;
        want[2] = sx < thr_low;
        want[3] = sx > thr_high;
        // a held direction button masks its stick direction
        want = want & ~buttons[3:0];
        dir_change = want ^ stick_held;
        total = $countones(pressed) + $countones(released) + $countones(dir_change);
        emitted = 0;

        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (pressed[i] || released[i]) begin
                emitted++;
                ev.key_code   = KEY_CODE[i];
                ev.key_down   = pressed[i];
                ev.last_event = (emitted == total);
                expected_keys.push_back(ev);
            end
        end
        for (int d = 0; d < NUM_DIRS; d++) begin
            if (dir_change[d]) begin
                emitted++;
                ev.key_code   = KEY_CODE[d];
                ev.key_down   = want[d];
                ev.last_event = (emitted == total);
                expected_keys.push_back(ev);
            end
        end
        btn_hist   = buttons;
        stick_held = want;
    endfunction

    function automatic logic [7:0] pick_stick();
        int r;
        int v;

        r = $urandom_range(99);
        if (r < 30)
            v = $urandom_range(255);
        else if (r < 60) begin
            v = ($urandom_range(1) ? int'(thr_low) : int'(thr_high))
                + int'($urandom_range(4)) - 2;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
        end
        else if (r < 80)
            v = 128;
        else
            v = $urandom_range(1) ? 255 : 0;
        return v[7:0];
    endfunction

    function automatic pad_sample_t random_sample();
        pad_sample_t s;
        int r;

        r = $urandom_range(99);
        if (r < 40) begin
            gen_buttons[$urandom_range(11)] ^= 1'b1;
            if ($urandom_range(1))
                gen_buttons[$urandom_range(11)] ^= 1'b1;
        end
        else if (r < 60)
            gen_buttons = 12'($urandom_range(4095));
        else if (r < 85) begin
            // leave buttons as they were
        end
        else
            gen_buttons = $urandom_range(1) ? 12'hFFF : 12'h000;
        s.buttons = gen_buttons;
        s.stick_x = pick_stick();
        s.stick_y = pick_stick();
        return s;
    endfunction

    // sample driver: hold a beat until taken, then pick the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid       <= 1'b0;
            sample_ch.button_bits <= '0;
            sample_ch.stick_x     <= '0;
            sample_ch.stick_y     <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                predict_keys(sample_ch.button_bits, sample_ch.stick_x, sample_ch.stick_y);
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (sample_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    next_sample = sample_q.pop_front();
                    sample_ch.valid       <= 1'b1;
                    sample_ch.button_bits <= next_sample.buttons;
                    sample_ch.stick_x     <= next_sample.stick_x;
                    sample_ch.stick_y     <= next_sample.stick_y;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // key event monitor and receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_ch.ready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (event_ch.valid && event_ch.ready)
            begin
                if (expected_keys.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected key event: code %h down %b last %b",
                                 event_ch.key_code, event_ch.key_down, event_ch.last_event);
                end
                else
                begin
                    exp_key = expected_keys.pop_front();
                    if (event_ch.key_code !== exp_key.key_code
                        || event_ch.key_down !== exp_key.key_down
                        || event_ch.last_event !== exp_key.last_event)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("key event mismatch: expected code %h down %b last %b, got code %h down %b last %b",
                                     exp_key.key_code, exp_key.key_down, exp_key.last_event,
                                     event_ch.key_code, event_ch.key_down, event_ch.last_event);
                    end
                end
            end
            if (stall_ack != stall_req)
            begin
                stall_ack = stall_req;
                hold_cnt = RX_HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                event_ch.ready <= 1'b0;
            end
            else
                event_ch.ready <= no_idle || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_THRESHOLD_LOW)
            thr_low = value;
        else
            thr_high = value;
    endtask

    task automatic push_sample(input logic [11:0] buttons, input logic [7:0] sx,
                               input logic [7:0] sy);
        pad_sample_t s;

        s.buttons = buttons;
        s.stick_x = sx;
        s.stick_y = sy;
        sample_q.push_back(s);
        gen_buttons = buttons;
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            sample_q.push_back(random_sample());
    endtask

    // wait until every sample is taken and every event is out, then let the front settle
    task automatic drain();
        while (sample_q.size() > 0 || sample_ch.valid || expected_keys.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_THRESHOLD_LOW;
        cfg_data    = '0;
        thr_low     = THRESHOLD_LOW_RESET;
        thr_high    = THRESHOLD_HIGH_RESET;
        btn_hist    = '0;
        stick_held  = '0;
        gen_buttons = '0;
        no_idle     = 1'b0;
        stall_req   = 0;
        stall_ack   = 0;
        mismatches  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: edges, suppression and threshold boundaries
        push_sample(12'h000, 8'd128, 8'd128);
        push_sample(12'hFFF, 8'd128, 8'd128);
        push_sample(12'hFFF, 8'd0,   8'd0);
        push_sample(12'h000, 8'd0,   8'd0);
        push_sample(12'h000, 8'd255, 8'd255);
        push_sample(12'h00F, 8'd255, 8'd255);
        push_sample(12'h00F, 8'd255, 8'd255);
        push_sample(12'h000, 8'd128, 8'd79);
        push_sample(12'h000, 8'd128, 8'd80);
        push_sample(12'h000, 8'd170, 8'd171);
        push_sample(12'h000, 8'd171, 8'd170);
        push_sample(12'h000, 8'd79,  8'd128);
        push_sample(12'h000, 8'd80,  8'd128);
        push_sample(12'h555, 8'd128, 8'd128);
        push_sample(12'hAAA, 8'd128, 8'd128);
        push_sample(12'hAAA, 8'd0,   8'd255);
        drain();

        // full-rate stretch
        no_idle = 1'b1;
        push_random(60);
        drain();
        no_idle = 1'b0;

        // stick can never trigger; stall the receiver while samples keep coming
        write_reg(REG_THRESHOLD_LOW, 8'd0);
        write_reg(REG_THRESHOLD_HIGH, 8'd255);
        push_random(30);
        stall_req++;
        drain();

        // thresholds crossed: all four directions at once, sixteen events in one sample
        write_reg(REG_THRESHOLD_LOW, 8'd200);
        write_reg(REG_THRESHOLD_HIGH, 8'd50);
        push_sample(12'h00F, 8'd128, 8'd128);
        push_sample(12'hFF0, 8'd128, 8'd128);
        push_sample(12'hFF0, 8'd128, 8'd128);
        push_sample(12'h000, 8'd255, 8'd255);
        push_random(25);
        drain();

        write_reg(REG_THRESHOLD_LOW, 8'd255);
        write_reg(REG_THRESHOLD_HIGH, 8'd0);
        push_random(30);
        drain();

        for (int k = 0; k < 2; k++)
        begin
            write_reg(REG_THRESHOLD_LOW, 8'($urandom_range(255)));
            write_reg(REG_THRESHOLD_HIGH, 8'($urandom_range(255)));
            push_random(25);
            drain();
        end

        write_reg(REG_THRESHOLD_LOW, THRESHOLD_LOW_RESET);
        write_reg(REG_THRESHOLD_HIGH, THRESHOLD_HIGH_RESET);
        push_random(15);
        drain();

        if (mismatches == 0 && expected_keys.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pkeg_pkg.sv
rtl/pkeg_if.sv
rtl/pkeg_front.sv
rtl/pkeg_queue.sv
rtl/pkeg_back.sv
rtl/pad_key_event_generator.sv
test/tb_pad_key_event_generator.sv
